// ===== rtl/jlvr_pkg.sv =====
package jlvr_pkg;

	// Field and register widths
	localparam int DATA_W    = 32;
	localparam int LIM_W     = 31;
	localparam int CFG_IDX_W = 3;

	// Derived widths of the internal arithmetic
	localparam int PROD_W      = 2 * DATA_W;
	localparam int COAST_SHIFT = 8;
	localparam int COAST_W     = PROD_W - COAST_SHIFT + 1;
	localparam int ERR_W       = COAST_W + 1;
	localparam int STEP_W      = DATA_W + 2;
	localparam int TRAP_SHIFT  = DATA_W + 1;
	localparam int TRAP_W      = PROD_W - TRAP_SHIFT;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes of the configuration port
	localparam cfg_idx_t REG_MAX_ACCEL         = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MAX_VELOCITY      = cfg_idx_t'(1);
	localparam cfg_idx_t REG_JERK_INCR         = cfg_idx_t'(2);
	localparam cfg_idx_t REG_HALF_INVERSE_JERK = cfg_idx_t'(3);
	localparam cfg_idx_t REG_TICK_PERIOD       = cfg_idx_t'(4);

	// Dead band around the velocity error: one LSB of Q16.16
	localparam logic signed [ERR_W-1:0] ERR_EPS_POS = ERR_W'(1);
	localparam logic signed [ERR_W-1:0] ERR_EPS_NEG = -ERR_W'(1);

	typedef struct packed {
		logic [LIM_W-1:0]  max_accel;
		logic [LIM_W-1:0]  max_velocity;
		logic [LIM_W-1:0]  jerk_incr;
		logic [DATA_W-1:0] half_inverse_jerk;
		logic [DATA_W-1:0] tick_period;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ,
		S_HI,
		S_LO,
		S_COAST,
		S_ERR,
		S_ACC,
		S_TRAP,
		S_VEL,
		S_FIN
	} seq_state_t;

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_HI,
		MUL_LO,
		MUL_TRAP
	} mul_sel_t;

	typedef struct packed {
		logic     load_target;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     save_lo;
		logic     save_hiprod;
		logic     save_coast;
		logic     save_want;
		logic     save_anew;
		logic     save_sum;
		logic     save_vel;
		logic     commit;
	} seq_ctrl_t;

	// Step value toward goal by at most step; lands on goal when within reach.
	function automatic logic signed [STEP_W-1:0] move_toward(
		input logic signed [STEP_W-1:0] value,
		input logic signed [STEP_W-1:0] goal,
		input logic signed [STEP_W-1:0] step
	);
		logic signed [STEP_W-1:0] res;
		if (value < goal - step) begin
			res = value + step;
		end else if (value > goal + step) begin
			res = value - step;
		end else begin
			res = goal;
		end
		return res;
	endfunction

	// Symmetric clamp to plus or minus an unsigned bound.
	function automatic logic signed [STEP_W-1:0] limit(
		input logic signed [STEP_W-1:0] value,
		input logic [LIM_W-1:0]         bound
	);
		logic signed [STEP_W-1:0] bnd;
		logic signed [STEP_W-1:0] res;
		bnd = $signed({{(STEP_W-LIM_W){1'b0}}, bound});
		if (value < -bnd) begin
			res = -bnd;
		end else if (value > bnd) begin
			res = bnd;
		end else begin
			res = value;
		end
		return res;
	endfunction

endpackage

// ===== rtl/jlvr_mul.sv =====
module jlvr_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [jlvr_pkg::DATA_W-1:0]   op_a,
	input  logic [jlvr_pkg::DATA_W-1:0]   op_b,
	output logic [jlvr_pkg::PROD_W-1:0]   prod
);
	import jlvr_pkg::*;

	logic [PROD_W-1:0] prod_s1;

	// Unsigned 32 by 32 multiply with the product registered.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
		end
	end

	assign prod = prod_s1;

endmodule

// ===== rtl/jlvr_cfg.sv =====
module jlvr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [jlvr_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [jlvr_pkg::DATA_W-1:0]      cfg_wdata,
	output jlvr_pkg::cfg_t                   cfg
);
	import jlvr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_ACCEL:         cfg_q.max_accel         <= cfg_wdata[LIM_W-1:0];
				REG_MAX_VELOCITY:      cfg_q.max_velocity      <= cfg_wdata[LIM_W-1:0];
				REG_JERK_INCR:         cfg_q.jerk_incr         <= cfg_wdata[LIM_W-1:0];
				REG_HALF_INVERSE_JERK: cfg_q.half_inverse_jerk <= cfg_wdata;
				REG_TICK_PERIOD:       cfg_q.tick_period       <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/jlvr_seq.sv =====
module jlvr_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_valid,
	input  logic                 out_ready,
	output logic                 in_ready,
	output jlvr_pkg::seq_ctrl_t  ctrl
);
	import jlvr_pkg::*;

	seq_state_t state_q;
	seq_state_t state_next;
	logic       out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_SQ;
				end
			end
			S_SQ:    state_next = S_HI;
			S_HI:    state_next = S_LO;
			S_LO:    state_next = S_COAST;
			S_COAST: state_next = S_ERR;
			S_ERR:   state_next = S_ACC;
			S_ACC:   state_next = S_TRAP;
			S_TRAP:  state_next = S_VEL;
			S_VEL:   state_next = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		ctrl.mul_sel = MUL_SQ;
		unique case (state_q)
			S_IDLE: begin
				in_ready         = 1'b1;
				ctrl.load_target = in_valid;
			end
			S_SQ: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_SQ;
			end
			S_HI: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_HI;
				ctrl.save_lo = 1'b1;
			end
			S_LO: begin
				ctrl.mul_en      = 1'b1;
				ctrl.mul_sel     = MUL_LO;
				ctrl.save_hiprod = 1'b1;
			end
			S_COAST: ctrl.save_coast = 1'b1;
			S_ERR:   ctrl.save_want  = 1'b1;
			S_ACC:   ctrl.save_anew  = 1'b1;
			S_TRAP: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_sel  = MUL_TRAP;
				ctrl.save_sum = 1'b1;
			end
			S_VEL:   ctrl.save_vel = 1'b1;
			S_FIN:   ctrl.commit   = out_free;
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SQ))
		else $error("accepted transaction did not start the sequence");

	a_commit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> (state_q == S_IDLE && in_ready))
		else $error("sequencer did not return to idle after commit");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("input ready raised while a transaction is in progress");
`endif

endmodule

// ===== rtl/jerk_limited_velocity_ramp.sv =====
// Jerk-limited velocity ramp: one S-curve profile update per control tick.
//
// Input channel (in_valid/in_ready, target_velocity): one transaction per tick
// carries the commanded velocity in signed Q16.16. The block takes a new
// transaction only when its sequencer is idle.
// Output channel (out_valid/out_ready, velocity_out, accel_out): one result
// transaction per input, giving the new velocity and acceleration in Q16.16.
// Configuration (cfg_we, cfg_addr, cfg_wdata): registers 0 to 4 are the
// acceleration limit, velocity limit, jerk step, half inverse jerk and tick
// period. Write them only while no transaction is in progress.
// Sequencing: a single registered 32 by 32 multiplier is reused four times per
// tick under a ten-state sequencer, and the block takes a new transaction only
// after the result of the last one has been committed to the output register.
// Reset clears the configuration and sets velocity and acceleration to rest.
// If the receiver stalls, the finished result waits in the output register;
// a following tick may still be accepted and computed, and it holds in its
// final step until the output register is free.
module jerk_limited_velocity_ramp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [jlvr_pkg::CFG_IDX_W-1:0]          cfg_addr,
	input  logic [jlvr_pkg::DATA_W-1:0]             cfg_wdata,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [jlvr_pkg::DATA_W-1:0]      target_velocity,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [jlvr_pkg::DATA_W-1:0]      velocity_out,
	output logic signed [jlvr_pkg::DATA_W-1:0]      accel_out
);
	import jlvr_pkg::*;

	cfg_t      cfg;
	seq_ctrl_t ctrl;

	// Profile state, cleared to rest by reset.
	logic signed [DATA_W-1:0] vel_q;
	logic signed [DATA_W-1:0] accel_q;

	// Working registers of one tick.
	logic signed [DATA_W-1:0]  target_q;
	logic [DATA_W-1:0]         lo_q;
	logic [PROD_W-1:0]         hiprod_q;
	logic signed [COAST_W-1:0] coast_q;
	logic signed [DATA_W-1:0]  want_q;
	logic signed [DATA_W-1:0]  anew_q;
	logic                      sum_neg_q;
	logic signed [STEP_W-1:0]  v1_q;

	// Output register.
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] velocity_out_q;
	logic signed [DATA_W-1:0] accel_out_q;

	// Shared multiplier.
	logic [DATA_W-1:0] mul_a;
	logic [DATA_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;

	logic [DATA_W-1:0]         accel_mag;
	logic [DATA_W-1:0]         anew_mag;
	logic signed [DATA_W:0]    sum_w;
	logic signed [DATA_W:0]    sum_abs;
	logic [PROD_W-1:0]         coast_sum;
	logic signed [COAST_W-1:0] coast_mag;
	logic signed [ERR_W-1:0]   err;
	logic signed [DATA_W-1:0]  acc_lim;
	logic signed [DATA_W-1:0]  want_next;
	logic signed [STEP_W-1:0]  step_w;
	logic signed [STEP_W-1:0]  anew_next;
	logic signed [STEP_W-1:0]  trap_d;
	logic                      snap;
	logic signed [STEP_W-1:0]  v_pre;
	logic signed [STEP_W-1:0]  a_snap;
	logic signed [STEP_W-1:0]  v_fin;
	logic signed [DATA_W-1:0]  a_fin;

	jlvr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	jlvr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_valid (out_valid_q),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.ctrl      (ctrl)
	);

	jlvr_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// Acceleration never reaches the most negative code, so its magnitude
	// fits the word unsigned.
	assign accel_mag = accel_q[DATA_W-1] ? DATA_W'(-accel_q) : DATA_W'(accel_q);
	assign anew_mag  = anew_q[DATA_W-1] ? DATA_W'(-anew_q) : DATA_W'(anew_q);

	// Trapezoid sum of old and new acceleration; its magnitude stays below 2^32.
	assign sum_w   = (DATA_W+1)'(accel_q) + (DATA_W+1)'(anew_q);
	assign sum_abs = sum_w[DATA_W] ? -sum_w : sum_w;

	// The multiplier runs |a|*|a|, then the high and low halves of that square
	// times the half inverse jerk, then the trapezoid sum times the tick period.
	always_comb begin
		case (ctrl.mul_sel)
			MUL_SQ: begin
				mul_a = accel_mag;
				mul_b = accel_mag;
			end
			MUL_HI: begin
				mul_a = prod[PROD_W-1:DATA_W];
				mul_b = cfg.half_inverse_jerk;
			end
			MUL_LO: begin
				mul_a = lo_q;
				mul_b = cfg.half_inverse_jerk;
			end
			MUL_TRAP: begin
				mul_a = sum_abs[DATA_W-1:0];
				mul_b = cfg.tick_period;
			end
			default: begin
				mul_a = accel_mag;
				mul_b = accel_mag;
			end
		endcase
	end

	// Coasting term: (square * half inverse jerk) / 2^40, truncated toward zero
	// and signed like the present acceleration.
	assign coast_sum = hiprod_q + PROD_W'(prod[PROD_W-1:DATA_W]);
	assign coast_mag = $signed({1'b0, coast_sum[PROD_W-1:COAST_SHIFT]});

	// Remaining error against the velocity reached when acceleration coasts out.
	assign err = ERR_W'(target_q) - ERR_W'(vel_q) - ERR_W'(coast_q);

	assign acc_lim = $signed({1'b0, cfg.max_accel});
	assign step_w  = $signed({{(STEP_W-LIM_W){1'b0}}, cfg.jerk_incr});

	always_comb begin
		if (err > ERR_EPS_POS) begin
			want_next = acc_lim;
		end else if (err < ERR_EPS_NEG) begin
			want_next = -acc_lim;
		end else begin
			want_next = '0;
		end
	end

	assign anew_next = limit(move_toward(STEP_W'(accel_q), STEP_W'(want_q), step_w),
		cfg.max_accel);

	// Velocity increment: half the sum times dt, i.e. product / 2^33.
	assign trap_d = $signed({{(STEP_W-TRAP_W){1'b0}}, prod[PROD_W-1:TRAP_SHIFT]});

	// Snap to the target once it is reached exactly with small acceleration;
	// acceleration then ramps toward zero. Velocity is clamped last.
	assign snap   = (v1_q == STEP_W'(target_q)) &&
		(anew_mag <= {{(DATA_W-LIM_W){1'b0}}, cfg.jerk_incr});
	assign a_snap = move_toward(STEP_W'(anew_q), '0, step_w);
	assign v_pre  = snap ? STEP_W'(target_q) : v1_q;
	assign a_fin  = snap ? a_snap[DATA_W-1:0] : anew_q;
	assign v_fin  = limit(v_pre, cfg.max_velocity);

	// Working registers: loaded under the sequencer, no reset needed.
	always_ff @(posedge clk) begin
		if (ctrl.load_target) begin
			target_q <= target_velocity;
		end
		if (ctrl.save_lo) begin
			lo_q <= prod[DATA_W-1:0];
		end
		if (ctrl.save_hiprod) begin
			hiprod_q <= prod;
		end
		if (ctrl.save_coast) begin
			coast_q <= accel_q[DATA_W-1] ? -coast_mag : coast_mag;
		end
		if (ctrl.save_want) begin
			want_q <= want_next;
		end
		if (ctrl.save_anew) begin
			anew_q <= anew_next[DATA_W-1:0];
		end
		if (ctrl.save_sum) begin
			sum_neg_q <= sum_w[DATA_W];
		end
		if (ctrl.save_vel) begin
			v1_q <= sum_neg_q ? STEP_W'(vel_q) - trap_d : STEP_W'(vel_q) + trap_d;
		end
		if (ctrl.commit) begin
			velocity_out_q <= v_fin[DATA_W-1:0];
			accel_out_q    <= a_fin;
		end
	end

	// Profile state and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q       <= '0;
			accel_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.commit) begin
				vel_q       <= v_fin[DATA_W-1:0];
				accel_q     <= a_fin;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign velocity_out = velocity_out_q;
	assign accel_out    = accel_out_q;

`ifndef SYNTHESIS
	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> out_valid_q)
		else $error("committed result not presented on the output");

	a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before its transaction completed");

	a_accel_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctrl.save_anew) |-> (anew_mag <= {1'b0, cfg.max_accel}))
		else $error("new acceleration outside the acceleration limit");
`endif

endmodule

// ===== tb/profile_checker.sv =====
module profile_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [jlvr_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [jlvr_pkg::DATA_W-1:0]        cfg_wdata,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [jlvr_pkg::DATA_W-1:0] target_velocity,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [jlvr_pkg::DATA_W-1:0] velocity_out,
	input  logic signed [jlvr_pkg::DATA_W-1:0] accel_out,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 results_seen
);
	import jlvr_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] velocity;
		logic signed [DATA_W-1:0] accel;
	} tick_result_t;

	// Dead band of the error and of the snap test: one LSB of Q16.16.
	localparam longint DEAD_BAND   = 1;
	localparam int     MAX_PRINTED = 40;

	logic [LIM_W-1:0]  accel_limit;
	logic [LIM_W-1:0]  velocity_limit;
	logic [LIM_W-1:0]  jerk_limit;
	logic [DATA_W-1:0] coast_gain;
	logic [DATA_W-1:0] dt;
	longint            vel_state;
	longint            acc_state;
	tick_result_t      expected_ticks[$];

	initial begin
		mismatches   = 0;
		pending      = 0;
		results_seen = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED) begin
			$display("profile_checker: result %0d: %s", results_seen, msg);
		end
		mismatches++;
	endtask

	function automatic logic [63:0] mag64(input longint x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint approach(input longint value, input longint goal,
			input longint stp);
		if (value < goal - stp) begin
			return value + stp;
		end else if (value > goal + stp) begin
			return value - stp;
		end
		return goal;
	endfunction

	function automatic longint clamp_sym(input longint value, input longint bound);
		if (value < -bound) begin
			return -bound;
		end else if (value > bound) begin
			return bound;
		end
		return value;
	endfunction

	// Velocity gained while the acceleration is ramped to zero: a*|a|/(2J).
	function automatic longint coast_offset(input longint a);
		logic [95:0] m;
		logic [95:0] prod;
		longint      t;
		m    = 96'(mag64(a));
		prod = m * m * 96'(coast_gain);
		t    = longint'(prod[95:40]);
		return (a < 0) ? -t : t;
	endfunction

	// Half the acceleration sum times dt, truncated toward zero.
	function automatic longint trapezoid_step(input longint sum);
		logic [95:0] prod;
		longint      d;
		prod = 96'(mag64(sum)) * 96'(dt);
		d    = longint'(prod[95:33]);
		return (sum < 0) ? -d : d;
	endfunction

	function automatic tick_result_t advance_profile(input logic signed [DATA_W-1:0] target_in);
		longint       tgt;
		longint       a_lim;
		longint       v_lim;
		longint       j_lim;
		longint       err;
		longint       want;
		longint       a_new;
		longint       v;
		tick_result_t r;
		tgt   = target_in;
		a_lim = longint'(accel_limit);
		v_lim = longint'(velocity_limit);
		j_lim = longint'(jerk_limit);
		err   = tgt - (vel_state + coast_offset(acc_state));
		want  = 0;
		if (err > DEAD_BAND) begin
			want = a_lim;
		end else if (err < -DEAD_BAND) begin
			want = -a_lim;
		end
		a_new = clamp_sym(approach(acc_state, want, j_lim), a_lim);
		v     = vel_state + trapezoid_step(acc_state + a_new);
		if (longint'(mag64(tgt - v)) < DEAD_BAND && longint'(mag64(a_new)) <= j_lim) begin
			v     = tgt;
			a_new = approach(a_new, 0, j_lim);
		end
		v          = clamp_sym(v, v_lim);
		vel_state  = v;
		acc_state  = a_new;
		r.velocity = DATA_W'(v);
		r.accel    = DATA_W'(a_new);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t head;
		if (!arst_n) begin
			accel_limit    = '0;
			velocity_limit = '0;
			jerk_limit     = '0;
			coast_gain     = '0;
			dt             = '0;
			vel_state      = 0;
			acc_state      = 0;
			expected_ticks.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_MAX_ACCEL:         accel_limit    = cfg_wdata[LIM_W-1:0];
					REG_MAX_VELOCITY:      velocity_limit = cfg_wdata[LIM_W-1:0];
					REG_JERK_INCR:         jerk_limit     = cfg_wdata[LIM_W-1:0];
					REG_HALF_INVERSE_JERK: coast_gain     = cfg_wdata;
					REG_TICK_PERIOD:       dt             = cfg_wdata;
					default: ;
				endcase
			end
			// Results leave in order, so a result seen on the same edge as a new
			// tick always belongs to an older one.
			if (out_valid && out_ready) begin
				if (expected_ticks.size() == 0) begin
					report_mismatch($sformatf("unexpected result v=%h a=%h",
						velocity_out, accel_out));
				end else begin
					head = expected_ticks.pop_front();
					if (velocity_out !== head.velocity) begin
						report_mismatch($sformatf("velocity_out %h, expected %h",
							velocity_out, head.velocity));
					end
					if (accel_out !== head.accel) begin
						report_mismatch($sformatf("accel_out %h, expected %h",
							accel_out, head.accel));
					end
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				expected_ticks.push_back(advance_profile(target_velocity));
			end
		end
		pending = expected_ticks.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the jerk-limited velocity ramp. This module only
// makes stimulus and gives the verdict; the profile_checker beside the block
// predicts every result and compares it.
module testbench;
	import jlvr_pkg::*;

	// Stimulus volume and timing guards.
	localparam int TOTAL_ITEMS       = 1320;
	localparam int LONG_HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT       = 20000;
	localparam int LATENCY_GUARD     = 24;
	localparam int WATCHDOG_TIME     = 1_000_000;
	localparam int ONE_Q16           = 65536;

	localparam logic signed [DATA_W-1:0] TARGET_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] TARGET_MIN = 32'sh8000_0000;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	cfg_idx_t                 cfg_addr;
	logic [DATA_W-1:0]        cfg_wdata;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DATA_W-1:0] target_velocity;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] velocity_out;
	logic signed [DATA_W-1:0] accel_out;

	int mismatches;
	int pending;
	int results_seen;

	// Stimulus bookkeeping, shared with the receiver process.
	int   items_sent;
	int   phase_count;
	bit   sender_steady;
	bit   ask_long_hold;
	cfg_t profile;

	jerk_limited_velocity_ramp i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.target_velocity (target_velocity),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.velocity_out    (velocity_out),
		.accel_out       (accel_out)
	);

	profile_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.target_velocity (target_velocity),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.velocity_out    (velocity_out),
		.accel_out       (accel_out),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_seen    (results_seen)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Gap before the next input transaction. Most are short; a few are long
	// enough to leave the sequencer idle for a while. Steady phases offer back
	// to back.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_steady || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input longint x);
		if (x > longint'(TARGET_MAX)) begin
			return TARGET_MAX;
		end else if (x < longint'(TARGET_MIN)) begin
			return TARGET_MIN;
		end
		return DATA_W'(x);
	endfunction

	// A plausible profile in physical units. The half inverse jerk is made to
	// agree with the jerk step: 1/(2J) = dt/(2*step), which in the register
	// formats works out to tick_period * 128 / jerk step. Now and then it is
	// replaced by noise so that mismatched settings get exercised as well.
	function automatic cfg_t realistic_profile();
		cfg_t   p;
		longint gain;
		p.tick_period  = $urandom_range(214748365, 1073741824);
		p.max_accel    = LIM_W'($urandom_range(ONE_Q16, 16 * ONE_Q16));
		p.jerk_incr    = LIM_W'(p.max_accel / $urandom_range(1, 6));
		gain           = (longint'(p.tick_period) * 128) / longint'(p.jerk_incr);
		p.max_velocity = LIM_W'($urandom_range(ONE_Q16 / 2, 12 * ONE_Q16));
		if ($urandom_range(0, 4) == 0) begin
			p.half_inverse_jerk = $urandom;
		end else begin
			p.half_inverse_jerk = DATA_W'(gain);
		end
		return p;
	endfunction

	function automatic cfg_t pick_profile();
		cfg_t p;
		int   r;
		r = $urandom_range(0, 99);
		p = realistic_profile();
		if (r < 55) begin
			return p;
		end else if (r < 65) begin
			p.jerk_incr = '0;
		end else if (r < 70) begin
			p.max_accel = '0;
		end else if (r < 75) begin
			p.max_velocity = '0;
		end else if (r < 85) begin
			p = '1;
		end else if (r < 90) begin
			p = '0;
		end else begin
			p = cfg_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		end
		return p;
	endfunction

	// Next commanded velocity, shaped by the present limits: most often inside
	// the velocity band, sometimes beyond it, sometimes a nudge of a few LSBs
	// around the previous target to probe the dead band and the snap.
	function automatic logic signed [DATA_W-1:0] pick_target(
		input logic signed [DATA_W-1:0] last
	);
		longint vmax;
		longint t;
		int     r;
		vmax = longint'(profile.max_velocity);
		r    = $urandom_range(0, 99);
		if (r < 45) begin
			t = longint'($urandom_range(0, 32'(2 * vmax))) - vmax;
		end else if (r < 60) begin
			t = vmax + longint'($urandom_range(1, 4 * ONE_Q16));
			if ($urandom_range(0, 1) == 1) begin
				t = -t;
			end
		end else if (r < 72) begin
			t = longint'(last) + longint'($urandom_range(1, 3));
			if ($urandom_range(0, 1) == 1) begin
				t = longint'(last) - longint'($urandom_range(1, 3));
			end
		end else if (r < 80) begin
			t = last;
		end else if (r < 90) begin
			t = longint'(signed'($urandom));
		end else begin
			t = ($urandom_range(0, 1) == 1) ? longint'(TARGET_MAX) : longint'(TARGET_MIN);
		end
		return sat32(t);
	endfunction

	// Offer one target as an input transaction and return at the falling edge
	// after it has been taken. Valid stays high on return, so the next call
	// either lowers it for a gap or replaces the payload in the same step.
	task automatic send_target(input logic signed [DATA_W-1:0] tv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		target_velocity <= tv;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every result still owed has come back, so
	// that the block is idle and may be reprogrammed.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// Write all five registers, one per cycle. The unused top bit of each
	// 31-bit register is filled with noise, which the block must ignore. On
	// request the unused indexes above the register map are hit as well.
	task automatic program_profile(input cfg_t p, input bit with_spares);
		profile = p;
		write_reg(REG_MAX_ACCEL,         {1'($urandom), p.max_accel});
		write_reg(REG_MAX_VELOCITY,      {1'($urandom), p.max_velocity});
		write_reg(REG_JERK_INCR,         {1'($urandom), p.jerk_incr});
		write_reg(REG_HALF_INVERSE_JERK, p.half_inverse_jerk);
		write_reg(REG_TICK_PERIOD,       p.tick_period);
		if (with_spares) begin
			for (int idx = int'(REG_TICK_PERIOD) + 1; idx < 2 ** CFG_IDX_W; idx++) begin
				write_reg(cfg_idx_t'(idx), $urandom);
			end
		end
		cfg_we <= 1'b0;
		phase_count++;
	endtask

	// Receiver: out_ready is dropped for random stretches, with calm stretches
	// in between where it stays high. Once, on request of the stimulus, it is
	// held low for a long count of cycles while targets keep coming, so the
	// finished result sits in the output register, the next tick completes
	// behind it, and the input side has to stall.
	initial begin
		int  stall_left;
		int  stretch_left;
		bit  steady;
		bit  long_hold_done;
		out_ready      = 1'b0;
		stall_left     = 0;
		stretch_left   = 0;
		steady         = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (ask_long_hold && !long_hold_done) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD_CYCLES;
			end
			if (stretch_left == 0) begin
				steady       = ($urandom_range(0, 3) == 0);
				stretch_left = $urandom_range(30, 200);
			end
			stretch_left--;
			if (stall_left == 0 && !steady) begin
				stall_left = pick_stall();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		cfg_t                     base;
		logic signed [DATA_W-1:0] tgt;
		int                       phase_left;
		int                       hold;
		int                       directed_items;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_addr        = '0;
		cfg_wdata       = '0;
		in_valid        = 1'b0;
		target_velocity = '0;
		items_sent      = 0;
		phase_count     = 0;
		sender_steady   = 1'b0;
		ask_long_hold   = 1'b0;
		profile         = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset every limit is zero: acceleration and velocity are both
		// pinned at rest whatever the command, including the two extremes.
		send_target(TARGET_MAX);
		send_target(TARGET_MIN);
		send_target('0);
		send_target(32'sd1);

		// A gentle profile: A = 4.0, V = 8.0, jerk step 1.0, dt = 0.1 s, so
		// 1/(2J) = 0.05. Extreme commands ramp towards the clamp, then back to
		// rest, then a one-LSB command either way sits inside the dead band.
		settle();
		base = '{max_accel: 31'd262144, max_velocity: 31'd524288, jerk_incr: 31'd65536,
			half_inverse_jerk: 32'd838861, tick_period: 32'd429496730};
		program_profile(base, 1'b1);
		repeat (4) send_target(TARGET_MAX);
		repeat (3) send_target(TARGET_MIN);
		repeat (3) send_target('0);
		send_target(32'sd1);
		send_target(-32'sd1);

		// With no jerk step the acceleration cannot change from its present value.
		settle();
		base.jerk_incr = '0;
		program_profile(base, 1'b0);
		repeat (2) send_target(32'sh0005_0000);

		// Full-scale registers: the widest products the datapath can see.
		settle();
		program_profile('1, 1'b0);
		send_target(TARGET_MAX);
		send_target(TARGET_MIN);
		directed_items = items_sent;

		// Random phases. Each one programs a fresh profile while idle, then
		// holds commands for a number of ticks so that the ramp has time to
		// develop, overshoot, snap or clamp. Single-tick commands act as noise.
		tgt = '0;
		while (items_sent < TOTAL_ITEMS) begin
			settle();
			program_profile(pick_profile(), 1'b0);
			sender_steady = ($urandom_range(0, 3) == 0);
			if (phase_count == 5) begin
				ask_long_hold = 1'b1;
			end
			phase_left = $urandom_range(60, 150);
			if (phase_left > TOTAL_ITEMS - items_sent) begin
				phase_left = TOTAL_ITEMS - items_sent;
			end
			while (phase_left > 0) begin
				tgt  = pick_target(tgt);
				hold = ($urandom_range(0, 99) < 15) ? 1 : $urandom_range(3, 30);
				for (int k = 0; k < hold && phase_left > 0; k++) begin
					send_target(tgt);
					phase_left--;
				end
			end
		end

		// Drain: every transaction still owed must come back, then a guard wait
		// catches anything the block might emit unasked.
		in_valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) begin
			@(negedge clk);
		end
		repeat (LATENCY_GUARD) @(negedge clk);

		$display("Drove %0d ticks (%0d directed) under %0d register settings; %0d results checked.",
			items_sent, directed_items, phase_count, results_seen);
		$display("Settings ranged from all-zero and zero-jerk to full scale, with one %0d-cycle %s",
			LONG_HOLD_CYCLES, "output hold-off.");
		if (mismatches == 0 && pending == 0) begin
			$display("jerk_limited_velocity_ramp verification clean");
		end else begin
			$display("jerk_limited_velocity_ramp verification failed");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#(WATCHDOG_TIME);
		$display("jerk_limited_velocity_ramp verification failed");
		$finish;
	end

endmodule
